>>> rtl/cio_pkg.sv
// ----------------------------------------------------------------------------
// cio_pkg - controller I/O port register block, shared definitions
// Register map, reset values, transaction structs and the pad read helper.
// ----------------------------------------------------------------------------
package cio_pkg;

  localparam int NUM_REGS_DEF = 16;
  localparam int IDX_W        = 4;
  localparam int BYTE_W       = 8;
  localparam int PC_W         = 3;

  // access kinds
  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // register map
  localparam logic [IDX_W-1:0] REG_VERSION = 4'd0;
  localparam logic [IDX_W-1:0] REG_DATA_A  = 4'd1;
  localparam logic [IDX_W-1:0] REG_DATA_B  = 4'd2;
  localparam logic [IDX_W-1:0] REG_DATA_C  = 4'd3;
  localparam logic [IDX_W-1:0] REG_CTRL_A  = 4'd4;
  localparam logic [IDX_W-1:0] REG_CTRL_B  = 4'd5;
  localparam logic [IDX_W-1:0] REG_CTRL_C  = 4'd6;

  localparam logic [BYTE_W-1:0] VERSION_RST   = 8'h80;
  localparam logic [BYTE_W-1:0] DATA_HOLD_BIT = 8'h80;
  localparam logic [BYTE_W-1:0] SELECT_BIT    = 8'h40;
  localparam logic [BYTE_W-1:0] PAD_FIXED     = 8'h03;
  localparam logic [BYTE_W-1:0] BYTE_ONES     = 8'hff;

  typedef struct packed {
    logic              wr;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] wdata;
    logic [BYTE_W-1:0] pad_a_hi;
    logic [BYTE_W-1:0] pad_a_lo;
    logic [BYTE_W-1:0] pad_b_hi;
    logic [BYTE_W-1:0] pad_b_lo;
  } acc_req_t;

  typedef struct packed {
    logic [2*BYTE_W-1:0] rdata;
    logic [PC_W-1:0]     pc_bits;
  } acc_rsp_t;

  // Pad byte for the current select level, with bit 7 of the data register.
  function automatic logic [BYTE_W-1:0] pad_read(
    input logic [BYTE_W-1:0] data,
    input logic [BYTE_W-1:0] ctrl,
    input logic [BYTE_W-1:0] hi,
    input logic [BYTE_W-1:0] lo
  );
    logic [BYTE_W-1:0] inmask;
    logic [BYTE_W-1:0] v;
    inmask = ctrl ^ BYTE_ONES;
    if ((data & SELECT_BIT) != '0) begin
      v = hi & inmask;
    end else begin
      v = (lo & inmask) | (hi & PAD_FIXED);
    end
    return (data & DATA_HOLD_BIT) | v;
  endfunction

endpackage

>>> rtl/console_io_port_registers.sv
// ----------------------------------------------------------------------------
// console_io_port_registers - controller I/O port register block
// Bus register accesses to the version, port data and control registers.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | req_type, reg_index, write_data, pads
//  out     | output    | out_valid/out_stall| read_data, port_c_bits
//  cfg     | input     | cfg_write_en       | cfg_version_byte
//
//  One transaction per cycle unless the input is stalled; a transaction passes
//  the input register and then the result register, with the register file
//  access between them. Reset is synchronous and clears the register file, the
//  port C latch and the pipeline valids; the version byte returns to 0x80.
//  A stalled output holds its result and input is stalled only while both
//  stages are full and the output is stalled.
module console_io_port_registers #(
  parameter int NUM_REGS = cio_pkg::NUM_REGS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [cio_pkg::BYTE_W-1:0]    cfg_version_byte,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [cio_pkg::IDX_W-1:0]     in_reg_index,
  input  logic [cio_pkg::BYTE_W-1:0]    in_write_data,
  input  logic [cio_pkg::BYTE_W-1:0]    in_pad_a_select_high,
  input  logic [cio_pkg::BYTE_W-1:0]    in_pad_a_select_low,
  input  logic [cio_pkg::BYTE_W-1:0]    in_pad_b_select_high,
  input  logic [cio_pkg::BYTE_W-1:0]    in_pad_b_select_low,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2*cio_pkg::BYTE_W-1:0]  out_read_data,
  output logic [cio_pkg::PC_W-1:0]      out_port_c_bits
);

  logic [cio_pkg::BYTE_W-1:0] ver_r;
  logic                       s1_vld_r;
  logic                       s1_vld_nxt;
  cio_pkg::acc_req_t          s1_req_r;
  logic                       out_vld_r;
  logic                       out_vld_nxt;
  cio_pkg::acc_rsp_t          out_rsp_r;
  cio_pkg::acc_rsp_t          rsp;
  logic                       in_acc;
  logic                       adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r <= cio_pkg::VERSION_RST;
    end else if (cfg_write_en) begin
      ver_r <= cfg_version_byte;
    end
  end

  // advance stage 1 into the result register whenever that is free
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && out_vld_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    s1_vld_nxt = s1_vld_r;
    if (in_acc) begin
      s1_vld_nxt = 1'b1;
    end else if (adv) begin
      s1_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (adv) begin
      out_vld_nxt = 1'b1;
    end else if (out_vld_r && !out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.wr       <= in_req_type;
      s1_req_r.idx      <= in_reg_index;
      s1_req_r.wdata    <= in_write_data;
      s1_req_r.pad_a_hi <= in_pad_a_select_high;
      s1_req_r.pad_a_lo <= in_pad_a_select_low;
      s1_req_r.pad_b_hi <= in_pad_b_select_high;
      s1_req_r.pad_b_lo <= in_pad_b_select_low;
    end
    if (adv) begin
      out_rsp_r <= rsp;
    end
  end

  cio_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .req     (s1_req_r),
    .version (ver_r),
    .rsp     (rsp)
  );

  assign out_valid       = out_vld_r;
  assign out_read_data   = out_rsp_r.rdata;
  assign out_port_c_bits = out_rsp_r.pc_bits;

endmodule

>>> rtl/cio_regfile.sv
// ----------------------------------------------------------------------------
// cio_regfile - register file and access logic
// Performs one read or write per enabled cycle and returns its response.
// ----------------------------------------------------------------------------
module cio_regfile #(
  parameter int NUM_REGS = cio_pkg::NUM_REGS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  cio_pkg::acc_req_t         req,
  input  logic [cio_pkg::BYTE_W-1:0] version,
  output cio_pkg::acc_rsp_t         rsp
);

  localparam int RI_W = $clog2(NUM_REGS);
  localparam logic [cio_pkg::IDX_W:0] DEPTH = (cio_pkg::IDX_W + 1)'(NUM_REGS);
  localparam logic [RI_W-1:0] DATA_A_I = RI_W'(cio_pkg::REG_DATA_A);
  localparam logic [RI_W-1:0] DATA_B_I = RI_W'(cio_pkg::REG_DATA_B);
  localparam logic [RI_W-1:0] CTRL_A_I = RI_W'(cio_pkg::REG_CTRL_A);
  localparam logic [RI_W-1:0] CTRL_B_I = RI_W'(cio_pkg::REG_CTRL_B);
  localparam logic [RI_W-1:0] CTRL_C_I = RI_W'(cio_pkg::REG_CTRL_C);

  logic [cio_pkg::BYTE_W-1:0] regs_r [NUM_REGS];
  logic [cio_pkg::PC_W-1:0]   pc_r;
  logic [cio_pkg::PC_W-1:0]   pc_nxt;

  logic                       in_range;
  logic [RI_W-1:0]            ridx;
  logic [cio_pkg::BYTE_W-1:0] cur;
  logic [cio_pkg::BYTE_W-1:0] ctrl;
  logic                       is_port;
  logic [cio_pkg::BYTE_W-1:0] wval;
  logic                       wr_en;
  logic [cio_pkg::BYTE_W-1:0] rbyte;

  assign in_range = {1'b0, req.idx} < DEPTH;
  assign ridx     = req.idx[RI_W-1:0];
  assign cur      = in_range ? regs_r[ridx] : '0;

  always_comb begin
    is_port = 1'b1;
    case (req.idx)
      cio_pkg::REG_DATA_A: ctrl = regs_r[CTRL_A_I];
      cio_pkg::REG_DATA_B: ctrl = regs_r[CTRL_B_I];
      cio_pkg::REG_DATA_C: ctrl = regs_r[CTRL_C_I];
      default: begin
        ctrl    = cio_pkg::BYTE_ONES;
        is_port = 1'b0;
      end
    endcase
  end

  // data ports keep their input bits, only output bits take the write
  assign wval  = is_port ? ((req.wdata & ctrl) | (cur & ~ctrl)) : req.wdata;
  assign wr_en = en && (req.wr == cio_pkg::REQ_WRITE) && in_range &&
                 (req.idx != cio_pkg::REG_VERSION);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (wr_en) begin
      regs_r[ridx] <= wval;
    end
  end

  always_comb begin
    pc_nxt = pc_r;
    if ((req.wr == cio_pkg::REQ_WRITE) && (req.idx == cio_pkg::REG_DATA_C)) begin
      pc_nxt = req.wdata[cio_pkg::PC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
    end else if (en) begin
      pc_r <= pc_nxt;
    end
  end

  always_comb begin
    unique case (req.idx)
      cio_pkg::REG_VERSION: rbyte = version;
      cio_pkg::REG_DATA_A:  rbyte = cio_pkg::pad_read(regs_r[DATA_A_I], regs_r[CTRL_A_I],
                                                      req.pad_a_hi, req.pad_a_lo);
      cio_pkg::REG_DATA_B:  rbyte = cio_pkg::pad_read(regs_r[DATA_B_I], regs_r[CTRL_B_I],
                                                      req.pad_b_hi, req.pad_b_lo);
      default:              rbyte = cur;
    endcase
  end

  // mirror the byte into both halves; writes return zero
  assign rsp.rdata   = (req.wr == cio_pkg::REQ_WRITE) ? '0 : {rbyte, rbyte};
  assign rsp.pc_bits = pc_nxt;

endmodule

>>> rtl/cio_checker.sv
// ----------------------------------------------------------------------------
// cio_checker - port-level checks for the I/O port register block
// Watches the top level's ports only; attached by bind.
// ----------------------------------------------------------------------------
module cio_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [2*cio_pkg::BYTE_W-1:0] out_read_data,
  input logic [cio_pkg::PC_W-1:0]     out_port_c_bits
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_data) &&
                               $stable(out_port_c_bits))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_read_data[15:8] == out_read_data[7:0])
    else $error("read byte not mirrored");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with result side free");

  // an accepted transaction reaches the output once the result side moves
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) ##1 !out_stall |=> out_valid)
    else $error("transaction lost");

endmodule

bind console_io_port_registers cio_checker u_cio_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_read_data   (out_read_data),
  .out_port_c_bits (out_port_c_bits)
);
